// ===== rtl/rsgg_pkg.sv =====
// Shared types, grid constants and slice arithmetic for the rotated sprite grid generator.
// Depends on nothing; imported by rsgg_slice, rotated_sprite_grid_generator and tb_top.
`default_nettype none

package rsgg_pkg;

  // Slicing grid. Both sizes must be powers of two so that every slice edge is exact.
  localparam int GRID_COLUMNS = 16;
  localparam int GRID_ROWS    = 4;
  localparam int MAX_RECORDS  = 64;

  localparam int COL_SHIFT = $clog2(GRID_COLUMNS);
  localparam int ROW_SHIFT = $clog2(GRID_ROWS);

  // Records emitted per request; the grid is cut off at the record limit.
  localparam int TOTAL_RECORDS =
      (GRID_ROWS * GRID_COLUMNS > MAX_RECORDS) ? MAX_RECORDS : GRID_ROWS * GRID_COLUMNS;
  localparam logic [5:0] LAST_IDX = 6'(TOTAL_RECORDS - 1);

  // Rotation register codes. Any code above the 180 degree one acts as 270 degrees.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;

  // One latched request word.
  typedef struct packed {
    logic [10:0] rect_x;
    logic [10:0] rect_y;
    logic [9:0]  rect_width;
    logic [9:0]  rect_height;
    logic [9:0]  tex_width;
    logic [9:0]  tex_height;
  } req_t;

  // One sprite record word.
  typedef struct packed {
    logic [5:0]  slice_index;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [13:0] u_start;
    logic [13:0] v_start;
    logic [13:0] u_end;
    logic [13:0] v_end;
    logic        last_slice;
  } rec_t;

  // Edge offset floor(d * 16 * k / GRID_COLUMNS) with 4 fraction bits, k at most GRID_COLUMNS.
  function automatic logic [13:0] part_cols(input logic [9:0] d, input logic [6:0] k);
    logic [20:0] prod;
    prod = {7'd0, d, 4'd0} * {14'd0, k};
    return 14'(prod >> COL_SHIFT);
  endfunction

  // Edge offset floor(d * 16 * k / GRID_ROWS) with 4 fraction bits, k at most GRID_ROWS.
  function automatic logic [13:0] part_rows(input logic [9:0] d, input logic [6:0] k);
    logic [20:0] prod;
    prod = {7'd0, d, 4'd0} * {14'd0, k};
    return 14'(prod >> ROW_SHIFT);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rsgg_slice.sv =====
// Combinational geometry of one sprite slice: screen and texture corners from the latched
// request, the rotation code and the slice index. Depends on rsgg_pkg.
`default_nettype none

module rsgg_slice (
  input  rsgg_pkg::req_t     req_i,
  input  logic [1:0]         rotation_i,
  input  logic [5:0]         index_i,
  output rsgg_pkg::rec_t     rec_o
);
  import rsgg_pkg::*;

  logic [6:0]  row_k;
  logic [6:0]  col_k;
  logic [16:0] x_base;
  logic [16:0] y_base;
  logic [16:0] x_far;
  logic [16:0] y_far;
  logic [13:0] w_col_s, w_col_e, w_row_s, w_row_e;
  logic [13:0] h_col_s, h_col_e, h_row_s, h_row_e;
  logic [16:0] xs, xe, ys, ye;

  // Row and column of this slice in the row-major grid.
  assign row_k = 7'(index_i / GRID_COLUMNS);
  assign col_k = 7'(index_i % GRID_COLUMNS);

  // Rectangle corners in fixed point, wide enough that no sum overflows.
  assign x_base = {{2{req_i.rect_x[10]}}, req_i.rect_x, 4'd0};
  assign y_base = {{2{req_i.rect_y[10]}}, req_i.rect_y, 4'd0};
  assign x_far  = x_base + {3'd0, req_i.rect_width, 4'd0};
  assign y_far  = y_base + {3'd0, req_i.rect_height, 4'd0};

  // Edge offsets along both grid directions.
  assign w_col_s = part_cols(req_i.rect_width, col_k);
  assign w_col_e = part_cols(req_i.rect_width, col_k + 7'd1);
  assign w_row_s = part_rows(req_i.rect_width, row_k);
  assign w_row_e = part_rows(req_i.rect_width, row_k + 7'd1);
  assign h_col_s = part_cols(req_i.rect_height, col_k);
  assign h_col_e = part_cols(req_i.rect_height, col_k + 7'd1);
  assign h_row_s = part_rows(req_i.rect_height, row_k);
  assign h_row_e = part_rows(req_i.rect_height, row_k + 7'd1);

  // Screen corners depend on the walk direction set by the rotation.
  always_comb begin
    unique case (rotation_i)
      ROT_0: begin
        xs = x_base + {3'd0, w_col_s};
        xe = x_base + {3'd0, w_col_e};
        ys = y_base + {3'd0, h_row_s};
        ye = y_base + {3'd0, h_row_e};
      end
      ROT_90: begin
        xs = x_far - {3'd0, w_row_s};
        xe = x_far - {3'd0, w_row_e};
        ys = y_base + {3'd0, h_col_s};
        ye = y_base + {3'd0, h_col_e};
      end
      ROT_180: begin
        xs = x_far - {3'd0, w_col_s};
        xe = x_far - {3'd0, w_col_e};
        ys = y_far - {3'd0, h_row_s};
        ye = y_far - {3'd0, h_row_e};
      end
      default: begin
        xs = x_base + {3'd0, w_row_s};
        xe = x_base + {3'd0, w_row_e};
        ys = y_far - {3'd0, h_col_s};
        ye = y_far - {3'd0, h_col_e};
      end
    endcase
  end

  // Assemble the record; the texture grid always runs row by row from zero.
  always_comb begin
    rec_o.slice_index = index_i;
    rec_o.x_start     = xs[15:0];
    rec_o.y_start     = ys[15:0];
    rec_o.x_end       = xe[15:0];
    rec_o.y_end       = ye[15:0];
    rec_o.u_start     = part_cols(req_i.tex_width, col_k);
    rec_o.u_end       = part_cols(req_i.tex_width, col_k + 7'd1);
    rec_o.v_start     = part_rows(req_i.tex_height, row_k);
    rec_o.v_end       = part_rows(req_i.tex_height, row_k + 7'd1);
    rec_o.last_slice  = (index_i == LAST_IDX);
  end

endmodule

`default_nettype wire

// ===== rtl/rotated_sprite_grid_generator.sv =====
// Top level of the rotated sprite grid generator: request latch, slice counter and record
// register around the slice geometry. Depends on rsgg_pkg and rsgg_slice.
// Start loads the request latch and slice counter, then one record per cycle is registered.
// Each request yields 64 records, set by the slice counter; busy drops
// during the last slice, so the next request starts without a gap.
// Reset clears the rotation to 0 degrees and returns the block to idle.
// The receiver cannot stall: each record is shown for one cycle under result_valid_o.
`default_nettype none

module rotated_sprite_grid_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [10:0] rect_x_i,
  input  logic signed [10:0] rect_y_i,
  input  logic [9:0]         rect_width_i,
  input  logic [9:0]         rect_height_i,
  input  logic [9:0]         tex_width_i,
  input  logic [9:0]         tex_height_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic [5:0]         slice_index_o,
  output logic signed [15:0] x_start_o,
  output logic signed [15:0] y_start_o,
  output logic signed [15:0] x_end_o,
  output logic signed [15:0] y_end_o,
  output logic [13:0]        u_start_o,
  output logic [13:0]        v_start_o,
  output logic [13:0]        u_end_o,
  output logic [13:0]        v_end_o,
  output logic               last_slice_o
);
  import rsgg_pkg::*;

  logic [1:0] rotation_q;
  logic       emitting_q, emitting_d;
  logic [5:0] counter_q, counter_d;
  req_t       req_q;
  rec_t       rec_d, rec_q;
  logic       valid_q;
  logic       at_last;
  logic       accept;

  // Rotation register, written whenever a word arrives on the configuration channel.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= ROT_0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rotation_q <= cfg_data_i;
    end
  end

  // A new request is taken while idle or during the final slice of the current one.
  assign at_last = emitting_q && (counter_q == LAST_IDX);
  assign busy    = emitting_q && !at_last;
  assign accept  = start && !busy;

  always_comb begin
    emitting_d = emitting_q;
    counter_d  = counter_q;
    if (accept) begin
      emitting_d = 1'b1;
      counter_d  = '0;
    end else if (at_last) begin
      emitting_d = 1'b0;
      counter_d  = '0;
    end else if (emitting_q) begin
      counter_d  = counter_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitting_q <= 1'b0;
      counter_q  <= '0;
    end else begin
      emitting_q <= emitting_d;
      counter_q  <= counter_d;
    end
  end

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.rect_x      <= rect_x_i;
      req_q.rect_y      <= rect_y_i;
      req_q.rect_width  <= rect_width_i;
      req_q.rect_height <= rect_height_i;
      req_q.tex_width   <= tex_width_i;
      req_q.tex_height  <= tex_height_i;
    end
  end

  // Slice geometry for the current counter value.
  rsgg_slice u_slice (
    .req_i      (req_q),
    .rotation_i (rotation_q),
    .index_i    (counter_q),
    .rec_o      (rec_d)
  );

  // Record register and its strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emitting_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emitting_q) begin
      rec_q <= rec_d;
    end
  end

  assign result_valid_o = valid_q;
  assign slice_index_o  = rec_q.slice_index;
  assign x_start_o      = rec_q.x_start;
  assign y_start_o      = rec_q.y_start;
  assign x_end_o        = rec_q.x_end;
  assign y_end_o        = rec_q.y_end;
  assign u_start_o      = rec_q.u_start;
  assign v_start_o      = rec_q.v_start;
  assign u_end_o        = rec_q.u_end;
  assign v_end_o        = rec_q.v_end;
  assign last_slice_o   = rec_q.last_slice;

  // A taken request starts at slice zero in the next cycle.
  a_start_slice_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> emitting_q && (counter_q == '0))
    else $error("request did not start at slice zero");

  // Every slice in work produces a record in the following cycle.
  a_record_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitting_q |=> result_valid_o && (slice_index_o == $past(counter_q)))
    else $error("record missing or out of order");

  // No record appears when no slice was in work.
  a_no_stray_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !emitting_q |=> !result_valid_o)
    else $error("record without a request");

  // The last flag marks exactly the final slice index.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_slice_o == (slice_index_o == LAST_IDX)))
    else $error("last flag on wrong slice");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the rotated sprite grid generator: drives requests under every
// rotation and compares each sprite record against an in-bench slice geometry predictor.
// Depends on rsgg_pkg and the rotated_sprite_grid_generator RTL.

module tb_top;
  import rsgg_pkg::*;

  // The register treats every code above the 180 degree one as 270 degrees.
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam int PHASE_ITEMS = 55;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    req_t req;
    bit   drain_first;
  } pending_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [10:0] rect_x = '0;
  logic signed [10:0] rect_y = '0;
  logic [9:0]         rect_width = '0;
  logic [9:0]         rect_height = '0;
  logic [9:0]         tex_width = '0;
  logic [9:0]         tex_height = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_data = '0;
  logic               result_valid;
  logic [5:0]         slice_index;
  logic signed [15:0] x_start, y_start, x_end, y_end;
  logic [13:0]        u_start, v_start, u_end, v_end;
  logic               last_slice;

  rotated_sprite_grid_generator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .rect_x_i       (rect_x),
    .rect_y_i       (rect_y),
    .rect_width_i   (rect_width),
    .rect_height_i  (rect_height),
    .tex_width_i    (tex_width),
    .tex_height_i   (tex_height),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .result_valid_o (result_valid),
    .slice_index_o  (slice_index),
    .x_start_o      (x_start),
    .y_start_o      (y_start),
    .x_end_o        (x_end),
    .y_end_o        (y_end),
    .u_start_o      (u_start),
    .v_start_o      (v_start),
    .u_end_o        (u_end),
    .v_end_o        (v_end),
    .last_slice_o   (last_slice)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pending_req_t pending_requests[$];
  rec_t         expected_records[$];
  logic [1:0]   rot_mode = ROT_0;
  int           error_count = 0;
  bit           burst_mode = 1'b0;
  int           idle_left = 0;
  req_t         cur_req;
  pending_req_t next_item;
  bit           next_start;
  rec_t         want;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("%0t ns: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("slice %0d %s: got %h, expected %h",
                                want.slice_index, name, got, exp_val));
  endtask

  // Fixed point slice edge: floor(d * 16 * k / n).
  function automatic int edge_off(input int d, input int k, input int n);
    return (d * 16 * k) / n;
  endfunction

  // Works out every sprite record of one request under the current rotation.
  task automatic predict_sprite_records(input req_t rq);
    int   px, py, w, h, tw, th, xw, yh, total, r, c, xs, xe, ys, ye;
    rec_t rec;
    px = int'($signed(rq.rect_x)) * 16;
    py = int'($signed(rq.rect_y)) * 16;
    w  = int'(rq.rect_width);
    h  = int'(rq.rect_height);
    tw = int'(rq.tex_width);
    th = int'(rq.tex_height);
    xw = px + w * 16;
    yh = py + h * 16;
    total = GRID_ROWS * GRID_COLUMNS;
    if (total > MAX_RECORDS) total = MAX_RECORDS;
    for (int i = 0; i < total; i++) begin
      r = i / GRID_COLUMNS;
      c = i % GRID_COLUMNS;
      case (rot_mode)
        ROT_0: begin
          xs = px + edge_off(w, c, GRID_COLUMNS);
          xe = px + edge_off(w, c + 1, GRID_COLUMNS);
          ys = py + edge_off(h, r, GRID_ROWS);
          ye = py + edge_off(h, r + 1, GRID_ROWS);
        end
        ROT_90: begin
          xs = xw - edge_off(w, r, GRID_ROWS);
          xe = xw - edge_off(w, r + 1, GRID_ROWS);
          ys = py + edge_off(h, c, GRID_COLUMNS);
          ye = py + edge_off(h, c + 1, GRID_COLUMNS);
        end
        ROT_180: begin
          xs = xw - edge_off(w, c, GRID_COLUMNS);
          xe = xw - edge_off(w, c + 1, GRID_COLUMNS);
          ys = yh - edge_off(h, r, GRID_ROWS);
          ye = yh - edge_off(h, r + 1, GRID_ROWS);
        end
        default: begin
          xs = px + edge_off(w, r, GRID_ROWS);
          xe = px + edge_off(w, r + 1, GRID_ROWS);
          ys = yh - edge_off(h, c, GRID_COLUMNS);
          ye = yh - edge_off(h, c + 1, GRID_COLUMNS);
        end
      endcase
      rec.slice_index = 6'(i);
      rec.x_start     = 16'(xs);
      rec.y_start     = 16'(ys);
      rec.x_end       = 16'(xe);
      rec.y_end       = 16'(ye);
      rec.u_start     = 14'(edge_off(tw, c, GRID_COLUMNS));
      rec.v_start     = 14'(edge_off(th, r, GRID_ROWS));
      rec.u_end       = 14'(edge_off(tw, c + 1, GRID_COLUMNS));
      rec.v_end       = 14'(edge_off(th, r + 1, GRID_ROWS));
      rec.last_slice  = (i == total - 1);
      expected_records.push_back(rec);
    end
  endtask

  // Request driver: takes requests from the pending queue with a random gap before each,
  // none in burst mode, and holds a marked request back until every record in flight is out.
  // The gap only counts down while the block is free, so it shows up on the input.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_sprite_records(cur_req);
        idle_left = burst_mode ? 0 : $urandom_range(0, 12);
      end
      if (start && busy) begin
        next_start = 1'b1;
      end else if (idle_left > 0) begin
        if (!busy) idle_left--;
        next_start = 1'b0;
      end else if (pending_requests.size() > 0 &&
                   !(pending_requests[0].drain_first && expected_records.size() != 0)) begin
        next_item = pending_requests.pop_front();
        cur_req = next_item.req;
        rect_x      <= cur_req.rect_x;
        rect_y      <= cur_req.rect_y;
        rect_width  <= cur_req.rect_width;
        rect_height <= cur_req.rect_height;
        tex_width   <= cur_req.tex_width;
        tex_height  <= cur_req.tex_height;
        next_start = 1'b1;
      end else begin
        next_start = 1'b0;
      end
      start <= next_start;
    end
  end

  // Record monitor: every strobed word must match the oldest expected record.
  always @(posedge clk) begin
    if (rst_n && result_valid) begin
      if (expected_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record, slice %0d", slice_index));
      end else begin
        want = expected_records.pop_front();
        compare_field("slice_index", 16'(slice_index), 16'(want.slice_index));
        compare_field("x_start", x_start, want.x_start);
        compare_field("y_start", y_start, want.y_start);
        compare_field("x_end", x_end, want.x_end);
        compare_field("y_end", y_end, want.y_end);
        compare_field("u_start", 16'(u_start), 16'(want.u_start));
        compare_field("v_start", 16'(v_start), 16'(want.v_start));
        compare_field("u_end", 16'(u_end), 16'(want.u_end));
        compare_field("v_end", 16'(v_end), 16'(want.v_end));
        compare_field("last_slice", 16'(last_slice), 16'(want.last_slice));
      end
    end
  end

  // Waits until no request is queued or in flight, then lets the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_records.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes the rotation register over its own channel; called right after a rising edge.
  task automatic write_rotation(input logic [1:0] mode);
    cfg_data  <= mode;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    rot_mode = mode;
  endtask

  function automatic req_t make_req(input logic [10:0] x, input logic [10:0] y,
                                    input logic [9:0] w, input logic [9:0] h,
                                    input logic [9:0] tw, input logic [9:0] th);
    req_t rq;
    rq.rect_x      = x;
    rq.rect_y      = y;
    rq.rect_width  = w;
    rq.rect_height = h;
    rq.tex_width   = tw;
    rq.tex_height  = th;
    return rq;
  endfunction

  // Sizes lean toward zero, the top value and small values that leave fractions.
  function automatic logic [9:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return 10'd0;
      1:       return 10'h3FF;
      2:       return 10'($urandom_range(1, 15));
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [10:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 11'h400;
      1:       return 11'h3FF;
      default: return 11'($urandom);
    endcase
  endfunction

  req_t directed_reqs[6];

  initial begin
    pending_req_t item;
    logic [1:0]   phase_rot[6];

    directed_reqs[0] = make_req(11'h400, 11'h400, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
    directed_reqs[1] = make_req(11'h3FF, 11'h3FF, 10'h3FF, 10'h3FF, 10'd0, 10'd0);
    directed_reqs[2] = make_req(11'd0, 11'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    directed_reqs[3] = make_req(11'd0, 11'd0, 10'd0, 10'h3FF, 10'h3FF, 10'd0);
    directed_reqs[4] = make_req(11'h7FF, 11'h7FF, 10'd1, 10'd1, 10'd1, 10'd1);
    directed_reqs[5] = make_req(11'h3FF, 11'h400, 10'd17, 10'd5, 10'd1000, 10'd3);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: corner sizes and positions, degenerate zero sizes, under each rotation.
    phase_rot = '{ROT_0, ROT_90, ROT_180, ROT_270, ROT_0, ROT_0};
    for (int p = 0; p < 4; p++) begin
      write_rotation(phase_rot[p]);
      for (int k = 0; k < 6; k++) begin
        item.req = directed_reqs[k];
        item.drain_first = 1'b0;
        pending_requests.push_back(item);
      end
      wait_drained();
    end

    // Random part: some phases back to back, the rest with random gaps; drain holds in every phase.
    phase_rot = '{ROT_90, ROT_0, ROT_270, 2'($urandom), 2'($urandom), ROT_180};
    for (int p = 0; p < 6; p++) begin
      write_rotation(phase_rot[p]);
      burst_mode = (p == 1 || p == 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        item.req = make_req(pick_coord(), pick_coord(), pick_size(), pick_size(),
                            pick_size(), pick_size());
        item.drain_first = (k == 10) || ($urandom_range(0, 19) == 0);
        pending_requests.push_back(item);
      end
      wait_drained();
    end
    burst_mode = 1'b0;

    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake or missing records.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rsgg_pkg.sv
rtl/rsgg_slice.sv
rtl/rotated_sprite_grid_generator.sv
test/tb_top.sv
